/* design/pcl_pkg.sv */
`timescale 1ns / 1ps

package pcl_pkg;

    // fixed widths of the shared datapath
    localparam int unsigned WORD_W = 64;
    localparam int unsigned ACC_W  = 192;
    localparam int unsigned STEP_W = 7;
    localparam int unsigned PC_W   = 6;
    localparam int unsigned UCODE_N = 37;

    // result fields
    localparam int unsigned CORR_W   = 16;
    localparam int unsigned FIT_W    = 32;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned OUT_W    = 96;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FEW    = 3'd1,
        ST_XCONST = 3'd2,
        ST_YCONST = 3'd3,
        ST_OVF    = 3'd4
    } fit_status_t;

    // operand limbs of the shared multiplier
    typedef enum logic [4:0] {
        SRC_ZERO, SRC_X, SRC_Y, SRC_N,
        SRC_SX_LO, SRC_SX_HI, SRC_SY_LO, SRC_SY_HI,
        SRC_SXY_LO, SRC_SXY_HI, SRC_SXX_LO, SRC_SXX_HI, SRC_SYY_LO, SRC_SYY_HI,
        SRC_CXX_LO, SRC_CXX_HI, SRC_CYY_LO, SRC_CYY_HI, SRC_MXY_LO, SRC_MXY_HI,
        SRC_SL_LO, SRC_SL_HI, SRC_K16, SRC_TRIAL, SRC_T2,
        SRC_P0, SRC_P1, SRC_P2, SRC_P3
    } src_t;

    // where a finished micro-op lands
    typedef enum logic [3:0] {
        D_NONE, D_SXY, D_SXX, D_SYY, D_CXY, D_CXX, D_CYY, D_P, D_L, D_NUM, D_T2
    } dst_t;

    typedef struct packed {
        src_t       opa;
        src_t       opb;
        logic [1:0] sh;     // product shift in 32-bit limbs
        logic       sub;
        logic       clr;    // start from zero instead of the accumulator
        dst_t       dst;
        logic       last;
    } uop_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    // program entry points
    localparam logic [PC_W-1:0] PC_ACC   = 6'd0;
    localparam logic [PC_W-1:0] PC_C     = 6'd3;
    localparam logic [PC_W-1:0] PC_PL    = 6'd18;
    localparam logic [PC_W-1:0] PC_NUM   = 6'd26;
    localparam logic [PC_W-1:0] PC_TRIAL = 6'd31;

    localparam uop_t UCODE [UCODE_N] = '{
        // per pair: products into the running sums
        '{SRC_X,      SRC_Y,      2'd0, 1'b0, 1'b1, D_SXY,  1'b0},
        '{SRC_X,      SRC_X,      2'd0, 1'b0, 1'b1, D_SXX,  1'b0},
        '{SRC_Y,      SRC_Y,      2'd0, 1'b0, 1'b1, D_SYY,  1'b1},
        // cxy = n*sxy - sx*sy modulo 2^64
        '{SRC_N,      SRC_SXY_LO, 2'd0, 1'b0, 1'b1, D_NONE, 1'b0},
        '{SRC_N,      SRC_SXY_HI, 2'd1, 1'b0, 1'b0, D_NONE, 1'b0},
        '{SRC_SX_LO,  SRC_SY_LO,  2'd0, 1'b1, 1'b0, D_NONE, 1'b0},
        '{SRC_SX_HI,  SRC_SY_LO,  2'd1, 1'b1, 1'b0, D_NONE, 1'b0},
        '{SRC_SX_LO,  SRC_SY_HI,  2'd1, 1'b1, 1'b0, D_CXY,  1'b0},
        // cxx
        '{SRC_N,      SRC_SXX_LO, 2'd0, 1'b0, 1'b1, D_NONE, 1'b0},
        '{SRC_N,      SRC_SXX_HI, 2'd1, 1'b0, 1'b0, D_NONE, 1'b0},
        '{SRC_SX_LO,  SRC_SX_LO,  2'd0, 1'b1, 1'b0, D_NONE, 1'b0},
        '{SRC_SX_HI,  SRC_SX_LO,  2'd1, 1'b1, 1'b0, D_NONE, 1'b0},
        '{SRC_SX_LO,  SRC_SX_HI,  2'd1, 1'b1, 1'b0, D_CXX,  1'b0},
        // cyy
        '{SRC_N,      SRC_SYY_LO, 2'd0, 1'b0, 1'b1, D_NONE, 1'b0},
        '{SRC_N,      SRC_SYY_HI, 2'd1, 1'b0, 1'b0, D_NONE, 1'b0},
        '{SRC_SY_LO,  SRC_SY_LO,  2'd0, 1'b1, 1'b0, D_NONE, 1'b0},
        '{SRC_SY_HI,  SRC_SY_LO,  2'd1, 1'b1, 1'b0, D_NONE, 1'b0},
        '{SRC_SY_LO,  SRC_SY_HI,  2'd1, 1'b1, 1'b0, D_CYY,  1'b1},
        // p = cxx*cyy, full 128 bits
        '{SRC_CXX_LO, SRC_CYY_LO, 2'd0, 1'b0, 1'b1, D_NONE, 1'b0},
        '{SRC_CXX_HI, SRC_CYY_LO, 2'd1, 1'b0, 1'b0, D_NONE, 1'b0},
        '{SRC_CXX_LO, SRC_CYY_HI, 2'd1, 1'b0, 1'b0, D_NONE, 1'b0},
        '{SRC_CXX_HI, SRC_CYY_HI, 2'd2, 1'b0, 1'b0, D_P,    1'b0},
        // l = mxy*mxy, scaled by 2^30 on write
        '{SRC_MXY_LO, SRC_MXY_LO, 2'd0, 1'b0, 1'b1, D_NONE, 1'b0},
        '{SRC_MXY_HI, SRC_MXY_LO, 2'd1, 1'b0, 1'b0, D_NONE, 1'b0},
        '{SRC_MXY_LO, SRC_MXY_HI, 2'd1, 1'b0, 1'b0, D_NONE, 1'b0},
        '{SRC_MXY_HI, SRC_MXY_HI, 2'd2, 1'b0, 1'b0, D_L,    1'b1},
        // intercept numerator sy*65536 - slope*sx modulo 2^64
        '{SRC_SY_LO,  SRC_K16,    2'd0, 1'b0, 1'b1, D_NONE, 1'b0},
        '{SRC_SY_HI,  SRC_K16,    2'd1, 1'b0, 1'b0, D_NONE, 1'b0},
        '{SRC_SL_LO,  SRC_SX_LO,  2'd0, 1'b1, 1'b0, D_NONE, 1'b0},
        '{SRC_SL_HI,  SRC_SX_LO,  2'd1, 1'b1, 1'b0, D_NONE, 1'b0},
        '{SRC_SL_LO,  SRC_SX_HI,  2'd1, 1'b1, 1'b0, D_NUM,  1'b1},
        // one root trial: trial squared, bubble, then trial^2 * p
        '{SRC_TRIAL,  SRC_TRIAL,  2'd0, 1'b0, 1'b1, D_T2,   1'b0},
        '{SRC_ZERO,   SRC_ZERO,   2'd0, 1'b0, 1'b1, D_NONE, 1'b0},
        '{SRC_T2,     SRC_P0,     2'd0, 1'b0, 1'b1, D_NONE, 1'b0},
        '{SRC_T2,     SRC_P1,     2'd1, 1'b0, 1'b0, D_NONE, 1'b0},
        '{SRC_T2,     SRC_P2,     2'd2, 1'b0, 1'b0, D_NONE, 1'b0},
        '{SRC_T2,     SRC_P3,     2'd3, 1'b0, 1'b0, D_NONE, 1'b1}
    };

endpackage

/* design/pearson_correlation_linear_fit.sv */
`timescale 1ns / 1ps
// a pair that is not last runs three products through the one shared 33x33 multiplier;
// a pair that arrives once the count is full is dropped without them
// a last pair gives its result after the shared multiplier sequencer, up to two passes of
// the 1-bit-per-cycle divider and a root search of up to 16 trials
// one pair in flight at a time; a waiting result does not block the next pair
// asynchronous active-low reset clears the sums, the count and all control state
module pearson_correlation_linear_fit
    import pcl_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // x_sample, y_sample, zero padding
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                    s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // correlation_q15, slope_q16, intercept_q8, pair_count, zero padding
    output logic [OUT_W-1:0]                        m_axis_tdata,
    // fit_status
    output logic [STATUS_W-1:0]                     m_axis_tuser
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SX_W   = (SAMPLE_BITS + CNT_W > 64) ? 64 : SAMPLE_BITS + CNT_W;
    localparam int SXY_W  = (2*SAMPLE_BITS + CNT_W > 64) ? 64 : 2*SAMPLE_BITS + CNT_W;
    localparam int SXX_W  = (2*SAMPLE_BITS + CNT_W - 1 > 64) ? 64 : 2*SAMPLE_BITS + CNT_W - 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RUN   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_DISP  = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    typedef enum logic [6:0] {
        PH_ACC   = 7'b0000001,
        PH_C     = 7'b0000010,
        PH_PL    = 7'b0000100,
        PH_SLOPE = 7'b0001000,
        PH_NUM   = 7'b0010000,
        PH_ICEPT = 7'b0100000,
        PH_TRIAL = 7'b1000000
    } phase_t;

    // control state
    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [PC_W-1:0]           pc_reg, pc_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;
    logic signed [SX_W-1:0]    sx_reg, sx_next;
    logic signed [SX_W-1:0]    sy_reg, sy_next;
    logic signed [SXY_W-1:0]   sxy_reg, sxy_next;
    logic signed [SXX_W-1:0]   sxx_reg, sxx_next;
    logic signed [SXX_W-1:0]   syy_reg, syy_next;
    logic                      ex_valid_reg, ex_valid_next;
    logic                      out_valid_reg, out_valid_next;

    // datapath
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;
    logic                      last_reg, last_next;
    uop_t                      ex_uop_reg, ex_uop_next;
    logic signed [65:0]        prod_reg, prod_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [WORD_W-1:0]         cxy_reg, cxy_next;
    logic [WORD_W-1:0]         cxx_reg, cxx_next;
    logic [WORD_W-1:0]         cyy_reg, cyy_next;
    logic [127:0]              p_reg, p_next;
    logic [ACC_W-1:0]          l_reg, l_next;
    logic [WORD_W-1:0]         num_reg, num_next;
    logic [31:0]               t2_reg, t2_next;
    logic [15:0]               trial_reg, trial_next;
    logic [15:0]               q_reg, q_next;
    logic [3:0]                rbit_reg, rbit_next;
    logic                      first_reg, first_next;
    logic [CORR_W-1:0]         corr_reg, corr_next;
    logic [FIT_W-1:0]          slope_reg, slope_next;
    logic [FIT_W-1:0]          icept_reg, icept_next;
    fit_status_t               status_reg, status_next;
    logic [OUT_W-1:0]          out_data_reg, out_data_next;
    logic [STATUS_W-1:0]       out_user_reg, out_user_next;

    // derived values
    logic signed [SAMPLE_BITS-1:0] x_in, y_in;
    logic [WORD_W-1:0]         sx64, sy64, sxy64, sxx64, syy64, n64, sl64, mxy;
    logic                      neg, cxx_bad, cyy_bad, slope_sat, pass, in_accept;
    uop_t                      cur_uop;
    logic [ACC_W-1:0]          shifted, base;
    logic [15:0]               qn, corr_val;
    logic [WORD_W-1:0]         div_q;
    logic                      div_busy;
    div_ctl_t                  div_ctl;
    logic [WORD_W-1:0]         div_rem, div_dvd, div_d;

    assign x_in  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign y_in  = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign sx64  = WORD_W'(sx_reg);
    assign sy64  = WORD_W'(sy_reg);
    assign sxy64 = WORD_W'(sxy_reg);
    assign sxx64 = WORD_W'(sxx_reg);
    assign syy64 = WORD_W'(syy_reg);
    assign n64   = WORD_W'(cnt_reg);
    assign sl64  = WORD_W'($signed(slope_reg));
    assign neg   = cxy_reg[WORD_W-1];
    assign mxy   = neg ? (~cxy_reg + 1'b1) : cxy_reg;
    assign cxx_bad = cxx_reg[WORD_W-1] || (cxx_reg == '0);
    assign cyy_bad = cyy_reg[WORD_W-1] || (cyy_reg == '0);
    // integer part of the slope would reach 2^15
    assign slope_sat = {15'b0, mxy} >= {cxx_reg, 15'b0};
    assign pass = acc_reg <= l_reg;
    assign cur_uop = UCODE[pc_reg];

    // operand limb selection for the shared multiplier
    function automatic logic signed [32:0] pick(input src_t s);
        logic signed [32:0] v;
        begin
            unique case (s)
                SRC_ZERO:   v = '0;
                SRC_X:      v = 33'(x_reg);
                SRC_Y:      v = 33'(y_reg);
                SRC_N:      v = $signed({1'b0, n64[31:0]});
                SRC_SX_LO:  v = $signed({1'b0, sx64[31:0]});
                SRC_SX_HI:  v = $signed({1'b0, sx64[63:32]});
                SRC_SY_LO:  v = $signed({1'b0, sy64[31:0]});
                SRC_SY_HI:  v = $signed({1'b0, sy64[63:32]});
                SRC_SXY_LO: v = $signed({1'b0, sxy64[31:0]});
                SRC_SXY_HI: v = $signed({1'b0, sxy64[63:32]});
                SRC_SXX_LO: v = $signed({1'b0, sxx64[31:0]});
                SRC_SXX_HI: v = $signed({1'b0, sxx64[63:32]});
                SRC_SYY_LO: v = $signed({1'b0, syy64[31:0]});
                SRC_SYY_HI: v = $signed({1'b0, syy64[63:32]});
                SRC_CXX_LO: v = $signed({1'b0, cxx_reg[31:0]});
                SRC_CXX_HI: v = $signed({1'b0, cxx_reg[63:32]});
                SRC_CYY_LO: v = $signed({1'b0, cyy_reg[31:0]});
                SRC_CYY_HI: v = $signed({1'b0, cyy_reg[63:32]});
                SRC_MXY_LO: v = $signed({1'b0, mxy[31:0]});
                SRC_MXY_HI: v = $signed({1'b0, mxy[63:32]});
                SRC_SL_LO:  v = $signed({1'b0, sl64[31:0]});
                SRC_SL_HI:  v = $signed({1'b0, sl64[63:32]});
                SRC_K16:    v = 33'sd65536;
                SRC_TRIAL:  v = $signed({17'b0, trial_reg});
                SRC_T2:     v = $signed({1'b0, t2_reg});
                SRC_P0:     v = $signed({1'b0, p_reg[31:0]});
                SRC_P1:     v = $signed({1'b0, p_reg[63:32]});
                SRC_P2:     v = $signed({1'b0, p_reg[95:64]});
                SRC_P3:     v = $signed({1'b0, p_reg[127:96]});
                default:    v = '0;
            endcase
            return v;
        end
    endfunction

    // accumulate stage of the shared unit
    assign shifted = ACC_W'(prod_reg) << {ex_uop_reg.sh, 5'b0};
    assign base    = ex_uop_reg.clr ? '0 : acc_reg;

    // next root candidate
    assign qn = first_reg ? 16'h8000 : (pass ? trial_reg : q_reg);
    assign corr_val = neg ? (~qn + 1'b1) : (qn[15] ? 16'h7FFF : qn);

    pcl_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .rem_init (div_rem),
        .dvd_init (div_dvd),
        .divisor  (div_d),
        .busy     (div_busy),
        .quot     (div_q)
    );

    // sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        sxy_next       = sxy_reg;
        sxx_next       = sxx_reg;
        syy_next       = syy_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        last_next      = last_reg;
        cxy_next       = cxy_reg;
        cxx_next       = cxx_reg;
        cyy_next       = cyy_reg;
        p_next         = p_reg;
        l_next         = l_reg;
        num_next       = num_reg;
        t2_next        = t2_reg;
        trial_next     = trial_reg;
        q_next         = q_reg;
        rbit_next      = rbit_reg;
        first_next     = first_reg;
        corr_next      = corr_reg;
        slope_next     = slope_reg;
        icept_next     = icept_reg;
        status_next    = status_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        div_ctl        = '0;
        div_rem        = '0;
        div_dvd        = '0;
        div_d          = '0;

        // issue stage: one product a cycle while a program runs
        ex_valid_next = (state_reg == S_RUN);
        ex_uop_next   = cur_uop;
        prod_next     = pick(cur_uop.opa) * pick(cur_uop.opb);

        // accumulate stage and write-back
        acc_next = acc_reg;
        if (ex_valid_reg)
        begin
            acc_next = ex_uop_reg.sub ? (base - shifted) : (base + shifted);
            unique case (ex_uop_reg.dst)
                D_NONE: ;
                D_SXY:  sxy_next = sxy_reg + prod_reg[SXY_W-1:0];
                D_SXX:  sxx_next = sxx_reg + prod_reg[SXX_W-1:0];
                D_SYY:  syy_next = syy_reg + prod_reg[SXX_W-1:0];
                D_CXY:  cxy_next = acc_next[WORD_W-1:0];
                D_CXX:  cxx_next = acc_next[WORD_W-1:0];
                D_CYY:  cyy_next = acc_next[WORD_W-1:0];
                D_P:    p_next   = acc_next[127:0];
                D_L:    l_next   = acc_next << 30;
                D_NUM:  num_next = acc_next[WORD_W-1:0];
                D_T2:   t2_next  = acc_next[31:0];
                default: ;
            endcase
        end

        // result taken downstream
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    x_next     = x_in;
                    y_next     = y_in;
                    last_next  = s_axis_tlast;
                    phase_next = PH_ACC;
                    if (cnt_reg >= CNT_W'(MAX_SAMPLES))
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_DISP;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        sx_next    = sx_reg + SX_W'(x_in);
                        sy_next    = sy_reg + SX_W'(y_in);
                        pc_next    = PC_ACC;
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                if (cur_uop.last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DISP;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_DISP;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b0, COUNT_W'(cnt_reg), icept_reg, slope_reg, corr_reg};
                    out_user_next  = status_reg;
                    cnt_next       = '0;
                    ovf_next       = 1'b0;
                    sx_next        = '0;
                    sy_next        = '0;
                    sxy_next       = '0;
                    sxx_next       = '0;
                    syy_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            S_DISP:
            begin
                unique case (phase_reg)
                    PH_ACC:
                    begin
                        if (!last_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            corr_next   = '0;
                            slope_next  = '0;
                            icept_next  = '0;
                            status_next = ST_OK;
                            priority if (ovf_reg)
                            begin
                                status_next = ST_OVF;
                                state_next  = S_OUT;
                            end
                            else if (cnt_reg < CNT_W'(2))
                            begin
                                status_next = ST_FEW;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                pc_next    = PC_C;
                                phase_next = PH_C;
                                state_next = S_RUN;
                            end
                        end
                    end
                    PH_C:
                    begin
                        if (cxx_bad)
                        begin
                            status_next = ST_XCONST;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            pc_next    = PC_PL;
                            phase_next = PH_PL;
                            state_next = S_RUN;
                        end
                    end
                    PH_PL:
                    begin
                        if (slope_sat)
                        begin
                            slope_next = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                            pc_next    = PC_NUM;
                            phase_next = PH_NUM;
                            state_next = S_RUN;
                        end
                        else
                        begin
                            // quotient bits below the top of mxy*2^16 / cxx
                            div_ctl.start = 1'b1;
                            div_ctl.steps = STEP_W'(31);
                            div_rem       = mxy >> 15;
                            div_dvd       = {mxy[14:0], 49'b0};
                            div_d         = cxx_reg;
                            phase_next    = PH_SLOPE;
                            state_next    = S_DIV;
                        end
                    end
                    PH_SLOPE:
                    begin
                        slope_next = neg ? (~{1'b0, div_q[30:0]} + 1'b1) : {1'b0, div_q[30:0]};
                        pc_next    = PC_NUM;
                        phase_next = PH_NUM;
                        state_next = S_RUN;
                    end
                    PH_NUM:
                    begin
                        div_ctl.start = 1'b1;
                        div_ctl.steps = STEP_W'(64);
                        div_rem       = '0;
                        div_dvd       = num_reg[WORD_W-1] ? (~num_reg + 1'b1) : num_reg;
                        div_d         = n64 << 8;
                        phase_next    = PH_ICEPT;
                        state_next    = S_DIV;
                    end
                    PH_ICEPT:
                    begin
                        // truncated toward zero, then saturated
                        if (num_reg[WORD_W-1])
                        begin
                            icept_next = (div_q > 64'h8000_0000) ? 32'h8000_0000
                                                                 : (~div_q[31:0] + 1'b1);
                        end
                        else
                        begin
                            icept_next = (|div_q[63:31]) ? 32'h7FFF_FFFF : div_q[31:0];
                        end
                        if (cyy_bad)
                        begin
                            status_next = ST_YCONST;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            trial_next = 16'h8000;
                            first_next = 1'b1;
                            pc_next    = PC_TRIAL;
                            phase_next = PH_TRIAL;
                            state_next = S_RUN;
                        end
                    end
                    PH_TRIAL:
                    begin
                        // bit-by-bit search for the largest q with q*q*p <= l
                        if ((first_reg && pass) || (!first_reg && rbit_reg == 4'd0))
                        begin
                            corr_next  = corr_val;
                            state_next = S_OUT;
                        end
                        else if (first_reg)
                        begin
                            first_next = 1'b0;
                            q_next     = '0;
                            rbit_next  = 4'd14;
                            trial_next = 16'h4000;
                            pc_next    = PC_TRIAL;
                            state_next = S_RUN;
                        end
                        else
                        begin
                            q_next     = qn;
                            rbit_next  = rbit_reg - 1'b1;
                            trial_next = qn | (16'd1 << (rbit_reg - 1'b1));
                            pc_next    = PC_TRIAL;
                            state_next = S_RUN;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_ACC;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sxy_reg       <= '0;
            sxx_reg       <= '0;
            syy_reg       <= '0;
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            sxy_reg       <= sxy_next;
            sxx_reg       <= sxx_next;
            syy_reg       <= syy_next;
            ex_valid_reg  <= ex_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        last_reg     <= last_next;
        ex_uop_reg   <= ex_uop_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        cxy_reg      <= cxy_next;
        cxx_reg      <= cxx_next;
        cyy_reg      <= cyy_next;
        p_reg        <= p_next;
        l_reg        <= l_next;
        num_reg      <= num_next;
        t2_reg       <= t2_next;
        trial_reg    <= trial_next;
        q_reg        <= q_next;
        rbit_reg     <= rbit_next;
        first_reg    <= first_next;
        corr_reg     <= corr_next;
        slope_reg    <= slope_next;
        icept_reg    <= icept_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

/* design/pcl_div.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module pcl_div
    import pcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_ctl_t          ctl,
    input  logic [WORD_W-1:0] rem_init,
    input  logic [WORD_W-1:0] dvd_init,
    input  logic [WORD_W-1:0] divisor,
    output logic              busy,
    output logic [WORD_W-1:0] quot
);

    logic              busy_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] dvd_reg;
    logic [WORD_W-1:0] d_reg;
    logic [WORD_W-1:0] q_reg;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;
    logic              fits;

    // trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, d_reg};
    assign fits    = shifted >= {1'b0, d_reg};

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ctl.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= rem_init;
            dvd_reg <= dvd_init;
            d_reg   <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            q_reg   <= {q_reg[WORD_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule
